### rtl/sc16fb_pkg.sv
// Shared definitions for the sync/CRC-16 frame builder.
// Holds the CRC polynomial, the sync reset constant, the emit phase type and CRC helpers.
// No dependencies.
package sc16fb_pkg;

  localparam logic [15:0] CRC_POLY   = 16'hA001;
  localparam logic [7:0]  SYNC_RESET = 8'h55;

  // Position of the byte being emitted within one item's result group
  typedef enum logic [1:0] {
    PH_SYNC   = 2'd0,
    PH_DATA   = 2'd1,
    PH_TRL_LO = 2'd2,
    PH_TRL_HI = 2'd3
  } phase_t;

  // Fold one byte into a reflected CRC-16, one bit per step
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // Mirror the bit order of a 16-bit word
  function automatic logic [15:0] rev16(input logic [15:0] v);
    logic [15:0] r;
    for (int k = 0; k < 16; k++) begin
      r[k] = v[15 - k];
    end
    return r;
  endfunction

endpackage

### rtl/sc16fb_crc.sv
// CRC-16 byte update for the frame builder: next accumulator and mirrored trailer.
// Depends on sc16fb_pkg.
module sc16fb_crc (
  input  logic [15:0] crc_in,
  input  logic [7:0]  data_in,
  output logic [15:0] crc_out,
  output logic [15:0] trailer
);

  // Fold the byte, then mirror the result for the trailer
  assign crc_out = sc16fb_pkg::crc_fold(crc_in, data_in);
  assign trailer = sc16fb_pkg::rev16(crc_out);

endmodule

### rtl/sync_crc16_frame_builder.sv
// Frame builder: sync byte, payload bytes, mirrored CRC-16 trailer (low byte first).
// An item's first byte passes through the item buffer and then the output register.
// Throughput: one output byte per cycle while out_stall is low; an item yields 1 to 4
// output bytes. Mid-frame bytes flow at one item per cycle while out_stall is low.
// Reset (rst_n low, synchronous): CRC cleared, waiting for a frame start, sync = 0x55.
module sync_crc16_frame_builder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_payload_byte,
  input  logic       in_frame_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last
);

  logic [7:0]          sync_r;
  logic [15:0]         crc_r, crc_nxt;
  logic                in_frame_r, in_frame_nxt;
  logic                a_valid_r, a_valid_nxt;
  sc16fb_pkg::phase_t  a_idx_r, a_idx_nxt;
  logic                a_last_r;
  logic [7:0]          a_byte_r;
  logic [15:0]         a_trl_r;
  logic                out_valid_r, out_valid_nxt;
  logic [7:0]          out_byte_r;
  logic                out_last_r;

  logic [15:0] crc_fold;
  logic [15:0] crc_trl;
  logic        out_ready;
  logic        a_fin;
  logic        move;
  logic        in_acc;
  logic [7:0]  emit_byte;

  sc16fb_crc u_crc (
    .crc_in  (crc_r),
    .data_in (in_payload_byte),
    .crc_out (crc_fold),
    .trailer (crc_trl)
  );

  // Handshake control
  assign out_ready = !out_valid_r || !out_stall;
  assign a_fin     = (a_idx_r == sc16fb_pkg::PH_TRL_HI) ||
                     ((a_idx_r == sc16fb_pkg::PH_DATA) && !a_last_r);
  assign move      = a_valid_r && out_ready;
  assign in_stall  = a_valid_r && !(move && a_fin);
  assign in_acc    = in_valid && !in_stall;

  // Select the byte for the current phase
  always_comb begin
    unique case (a_idx_r)
      sc16fb_pkg::PH_SYNC:   emit_byte = sync_r;
      sc16fb_pkg::PH_DATA:   emit_byte = a_byte_r;
      sc16fb_pkg::PH_TRL_LO: emit_byte = a_trl_r[7:0];
      sc16fb_pkg::PH_TRL_HI: emit_byte = a_trl_r[15:8];
      default:               emit_byte = a_byte_r;
    endcase
  end

  // Frame state and item buffer next values
  always_comb begin
    crc_nxt      = crc_r;
    in_frame_nxt = in_frame_r;
    a_valid_nxt  = a_valid_r;
    a_idx_nxt    = a_idx_r;
    if (in_acc) begin
      crc_nxt      = in_frame_end ? 16'h0000 : crc_fold;
      in_frame_nxt = !in_frame_end;
      a_valid_nxt  = 1'b1;
      a_idx_nxt    = in_frame_r ? sc16fb_pkg::PH_DATA : sc16fb_pkg::PH_SYNC;
    end else if (move && a_fin) begin
      a_valid_nxt = 1'b0;
    end else if (move) begin
      a_idx_nxt = sc16fb_pkg::phase_t'(a_idx_r + 2'd1);
    end
    out_valid_nxt = out_valid_r;
    if (move) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r      <= sc16fb_pkg::SYNC_RESET;
      crc_r       <= 16'h0000;
      in_frame_r  <= 1'b0;
      a_valid_r   <= 1'b0;
      a_idx_r     <= sc16fb_pkg::PH_SYNC;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        sync_r <= cfg_wr_data;
      end
      crc_r       <= crc_nxt;
      in_frame_r  <= in_frame_nxt;
      a_valid_r   <= a_valid_nxt;
      a_idx_r     <= a_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: capture item, then hand bytes to the output
  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_byte_r <= in_payload_byte;
      a_last_r <= in_frame_end;
      a_trl_r  <= crc_trl;
    end
    if (move) begin
      out_byte_r <= emit_byte;
      out_last_r <= (a_idx_r == sc16fb_pkg::PH_TRL_HI);
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

  // Checks
  a_acc_only_on_final: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && a_valid_r) |-> (move && a_fin))
    else $error("item taken while buffer still has bytes to send");

  a_crc_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_frame_end) |=> (crc_r == 16'h0000 && !in_frame_r))
    else $error("CRC not cleared after frame end");

  a_start_sync: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_frame_r) |=> (a_valid_r && a_idx_r == sc16fb_pkg::PH_SYNC))
    else $error("frame start without sync phase");

  a_trailer_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    (a_valid_r && (a_idx_r == sc16fb_pkg::PH_TRL_LO || a_idx_r == sc16fb_pkg::PH_TRL_HI))
      |-> a_last_r)
    else $error("trailer phase on a non-final item");

endmodule

### sim/tb.sv
// Testbench for sync_crc16_frame_builder: frames payload bytes and checks sync, data and
// mirrored CRC-16/ARC trailers against a built-in frame predictor, under random idling.
// Depends on rtl/sc16fb_pkg.sv and rtl/sync_crc16_frame_builder.sv.
`timescale 1ns / 1ps

module tb;

  localparam int QUIET_LIMIT  = 2000;  // cycles with no item moving on either side
  localparam int DRAIN_CYCLES = 4;     // idle cycles after the last byte, some margin
  localparam int ITEMS_PER_MODE = 170;

  typedef struct packed {
    logic [7:0] fbyte;
    logic       last;
  } frame_byte_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = 8'h00;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_payload_byte = 8'h00;
  logic       in_frame_end = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       out_last;

  // Predictor state
  logic [15:0] crc_run = 16'h0000;
  logic        in_frame = 1'b0;
  logic [7:0]  sync_byte = sc16fb_pkg::SYNC_RESET;
  frame_byte_t frame_byte_q[$];

  int fail_count = 0;
  int quiet_cycles = 0;
  int send_gap_pct = 0;
  int recv_stall_pct = 0;

  sync_crc16_frame_builder dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_payload_byte(in_payload_byte),
    .in_frame_end   (in_frame_end),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_last       (out_last)
  );

  always #6 clk = ~clk;

  // Reflected CRC-16 update, one data bit per step
  function automatic logic [15:0] arc_update(input logic [15:0] acc, input logic [7:0] d);
    logic [15:0] r;
    logic        fb;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ d[i];
      r  = r >> 1;
      if (fb) begin
        r = r ^ sc16fb_pkg::CRC_POLY;
      end
    end
    return r;
  endfunction

  // Mirror a 16-bit word by shifting bits out of one end into the other
  function automatic logic [15:0] mirror16(input logic [15:0] v);
    logic [15:0] m;
    logic [15:0] s;
    m = 16'h0000;
    s = v;
    for (int i = 0; i < 16; i++) begin
      m = {m[14:0], s[0]};
      s = s >> 1;
    end
    return m;
  endfunction

  // Queue the frame bytes that one accepted payload item produces
  function automatic void predict_frame_bytes(input logic [7:0] b, input logic e);
    logic [15:0] trailer;
    if (!in_frame) begin
      frame_byte_q.push_back('{fbyte: sync_byte, last: 1'b0});
      in_frame = 1'b1;
    end
    frame_byte_q.push_back('{fbyte: b, last: 1'b0});
    crc_run = arc_update(crc_run, b);
    if (e) begin
      trailer = mirror16(crc_run);
      frame_byte_q.push_back('{fbyte: trailer[7:0], last: 1'b0});
      frame_byte_q.push_back('{fbyte: trailer[15:8], last: 1'b1});
      crc_run  = 16'h0000;
      in_frame = 1'b0;
    end
  endfunction

  // Receiver side: stall at the configured rate
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Check each accepted frame byte against the oldest expectation
  always @(posedge clk) begin
    frame_byte_t exp_b;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (frame_byte_q.size() == 0) begin
        $error("unexpected frame byte: out_byte=%02h out_last=%0b", out_byte, out_last);
        fail_count++;
      end else begin
        exp_b = frame_byte_q.pop_front();
        if (out_byte !== exp_b.fbyte) begin
          $error("out_byte: expected %02h, actual %02h", exp_b.fbyte, out_byte);
          fail_count++;
        end
        if (out_last !== exp_b.last) begin
          $error("out_last: expected %0b, actual %0b", exp_b.last, out_last);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Offer one payload item, idle first at the sender rate, hold until accepted
  task automatic send_item(input logic [7:0] b, input logic e);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_payload_byte <= b;
    in_frame_end    <= e;
    do begin
      @(posedge clk);
    end while (in_stall !== 1'b0);
    predict_frame_bytes(b, e);
  endtask

  // Drop valid and wait until every expected byte is out and the block is quiet
  task automatic drain_frames();
    in_valid <= 1'b0;
    while (frame_byte_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write the sync register while the block is idle
  task automatic write_sync(input logic [7:0] v);
    drain_frames();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sync_byte = v;
  endtask

  task automatic send_random_frame(input int len);
    for (int i = 0; i < len; i++) begin
      send_item(8'($urandom_range(0, 255)), i == len - 1);
    end
  endtask

  // Default sync after reset, one-byte frames at the byte extremes
  task automatic test_reset_defaults();
    send_item(8'h00, 1'b1);
    send_item(8'hFF, 1'b1);
  endtask

  // Known check string and a short frame with the top and bottom bits set
  task automatic test_known_frames();
    string check_str;
    check_str = "123456789";
    for (int i = 0; i < check_str.len(); i++) begin
      send_item(check_str[i], i == check_str.len() - 1);
    end
    send_item(8'h80, 1'b0);
    send_item(8'h01, 1'b1);
  endtask

  // Sync register at both extremes
  task automatic test_sync_extremes();
    write_sync(8'h00);
    send_item(8'hAA, 1'b1);
    write_sync(8'hFF);
    send_item(8'h55, 1'b0);
    send_item(8'h7F, 1'b1);
  endtask

  // Sync change in the middle of a frame applies only from the next frame on
  task automatic test_mid_frame_sync();
    write_sync(8'h3C);
    send_item(8'h11, 1'b0);
    send_item(8'h22, 1'b0);
    send_item(8'h33, 1'b0);
    write_sync(8'hA5);
    send_item(8'h44, 1'b0);
    send_item(8'h55, 1'b1);
    send_item(8'h66, 1'b1);
  endtask

  // Random frames, mostly short, a few long, with sync rewrites between frames
  task automatic test_random_frames(input int gap_pct, input int stall_pct);
    int sent;
    int len;
    sent = 0;
    drain_frames();
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
    while (sent < ITEMS_PER_MODE) begin
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 3))
          0: write_sync(8'h00);
          1: write_sync(8'hFF);
          default: write_sync(8'($urandom_range(0, 255)));
        endcase
      end
      if ($urandom_range(0, 15) == 0) begin
        len = $urandom_range(20, 40);
      end else if ($urandom_range(0, 3) == 0) begin
        len = 1;
      end else begin
        len = $urandom_range(2, 8);
      end
      send_random_frame(len);
      sent += len;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_known_frames();
    test_sync_extremes();
    test_mid_frame_sync();
    test_random_frames(24, 61);
    test_random_frames(61, 24);
    test_random_frames(0, 0);

    // Let the last bytes out, then settle
    drain_frames();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
